/* design/tkst_pkg.sv */
// ----------------------------------------------------------------------------
// tkst_pkg
// Types and constants shared by the top-k score table and its cells.
// ----------------------------------------------------------------------------
package tkst_pkg;

   // default table depth
   localparam int CAPACITY_DEF = 10;

   // field widths
   localparam int SCORE_W = 24;
   localparam int TAG_W   = 16;
   localparam int STAMP_W = 32;
   localparam int RANK_W  = 4;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   // one table entry
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic      shift_en;   // accepted insert that enters the table
      entry_type new_entry;  // entry offered by the request
   } cell_ctrl_type;

   // status handed back by each cell
   typedef struct packed {
      logic ge;              // filled and score >= offered score
      logic take_new;        // this cell is the insert point
   } cell_stat_type;

   // registered response payload
   typedef struct packed {
      logic [RANK_W-1:0]  placed_rank;
      logic               would_enter;
      logic               entry_valid;
      logic [SCORE_W-1:0] entry_score;
      logic [TAG_W-1:0]   entry_tag;
      logic [STAMP_W-1:0] entry_stamp;
      logic [RANK_W-1:0]  filled_count;
   } rsp_type;

endpackage

/* design/tkst_ifs.sv */
// ----------------------------------------------------------------------------
// tkst request / response channels
// Valid-ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface tkst_req_if
   import tkst_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [SCORE_W-1:0] new_score;
   logic [TAG_W-1:0]   player_tag;
   logic [STAMP_W-1:0] stamp;
   logic [RANK_W-1:0]  read_rank;

   modport source (output valid, req_type, new_score, player_tag, stamp, read_rank,
                   input  ready);
   modport sink   (input  valid, req_type, new_score, player_tag, stamp, read_rank,
                   output ready);
endinterface

interface tkst_rsp_if
   import tkst_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [RANK_W-1:0]  placed_rank;
   logic               would_enter;
   logic               entry_valid;
   logic [SCORE_W-1:0] entry_score;
   logic [TAG_W-1:0]   entry_tag;
   logic [STAMP_W-1:0] entry_stamp;
   logic [RANK_W-1:0]  filled_count;

   modport source (output valid, placed_rank, would_enter, entry_valid, entry_score,
                          entry_tag, entry_stamp, filled_count,
                   input  ready);
   modport sink   (input  valid, placed_rank, would_enter, entry_valid, entry_score,
                          entry_tag, entry_stamp, filled_count,
                   output ready);
endinterface

/* design/top_k_score_table.sv */
// ----------------------------------------------------------------------------
// top_k_score_table
// Bounded table of the best scores, sorted high to low, built as a chain of
// compare-and-shift cells.
// ----------------------------------------------------------------------------
// The table takes one request per clock and answers each with one response
// on the following cycle; a request is taken whenever the response register
// is empty or being drained. Every cell compares its own score against the
// offered one in parallel and shifts from its upper neighbor in the same
// cycle, so insert time does not grow with depth; the critical path is the
// score compare plus the rank encoder and read select across CAPACITY cells.
// The table is empty after reset; no clearing pass is needed.
module top_k_score_table
   import tkst_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic     clock,
   input  logic     reset,
   tkst_req_if.sink   req_ch,
   tkst_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] used_ff;
   logic [CNT_W-1:0] used_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   cell_ctrl_type    ctrl;
   entry_type        cell_entry [CAPACITY];
   cell_stat_type    cell_stat  [CAPACITY];

   logic             accept;
   logic             full;
   logic             enter;
   logic             rd_valid;
   entry_type        rd_entry;
   logic [RANK_W-1:0] placed;

   // handshake
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // admission test against the last slot
   assign full  = (used_ff == CNT_W'(CAPACITY));
   assign enter = !full || (req_ch.new_score > cell_entry[CAPACITY-1].score);

   // broadcast to the chain
   assign ctrl.shift_en            = accept && (req_ch.req_type == REQ_INSERT) && enter;
   assign ctrl.new_entry.score     = req_ch.new_score;
   assign ctrl.new_entry.tag       = req_ch.player_tag;
   assign ctrl.new_entry.stamp     = req_ch.stamp;

   // cell chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         tkst_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .filled     (used_ff > CNT_W'(g)),
            .prev_ge    (1'b1),
            .prev_entry (ctrl.new_entry),
            .entry      (cell_entry[g]),
            .stat       (cell_stat[g])
         );
      end else begin : g_body
         tkst_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .filled     (used_ff > CNT_W'(g)),
            .prev_ge    (cell_stat[g-1].ge),
            .prev_entry (cell_entry[g-1]),
            .entry      (cell_entry[g]),
            .stat       (cell_stat[g])
         );
      end
   end

   // rank encoder for the insert point
   always_comb begin
      placed = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_stat[i].take_new) begin
            placed = RANK_W'(i + 1);
         end
      end
   end

   // read select
   assign rd_valid = (req_ch.read_rank != '0) && (int'(req_ch.read_rank) <= int'(used_ff));

   always_comb begin
      rd_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (int'(req_ch.read_rank) == i + 1) begin
            rd_entry = cell_entry[i];
         end
      end
   end

   // fill count and response build
   always_comb begin
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      if (ctrl.shift_en && !full) begin
         used_in = used_ff + CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_in              = '0;
         rsp_in.would_enter  = enter;
         rsp_in.filled_count = RANK_W'(used_in);
         if (req_ch.req_type == REQ_INSERT) begin
            if (enter) begin
               rsp_in.placed_rank = placed;
            end
         end else if (rd_valid) begin
            rsp_in.entry_valid = 1'b1;
            rsp_in.entry_score = rd_entry.score;
            rsp_in.entry_tag   = rd_entry.tag;
            rsp_in.entry_stamp = rd_entry.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // response channel
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.placed_rank  = rsp_ff.placed_rank;
   assign rsp_ch.would_enter  = rsp_ff.would_enter;
   assign rsp_ch.entry_valid  = rsp_ff.entry_valid;
   assign rsp_ch.entry_score  = rsp_ff.entry_score;
   assign rsp_ch.entry_tag    = rsp_ff.entry_tag;
   assign rsp_ch.entry_stamp  = rsp_ff.entry_stamp;
   assign rsp_ch.filled_count = rsp_ff.filled_count;

endmodule

/* design/tkst_cell.sv */
// ----------------------------------------------------------------------------
// tkst_cell
// One slot of the sorted chain: compares its score against the offered one
// and either keeps its entry, loads the new entry or takes its upper neighbor.
// ----------------------------------------------------------------------------
module tkst_cell
   import tkst_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          filled,      // slot holds a valid entry
   input  logic          prev_ge,     // upper neighbor stays put (1 at the head)
   input  entry_type     prev_entry,  // upper neighbor's entry
   output entry_type     entry,
   output cell_stat_type stat
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      ge;

   // equal or better entries stay ahead of the new one
   assign ge = filled && (entry_ff.score >= ctrl.new_entry.score);

   assign stat.ge       = ge;
   assign stat.take_new = !ge && prev_ge;
   assign entry         = entry_ff;

   // keep, load new, or shift down from neighbor
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_en && !ge) begin
         entry_in = prev_ge ? ctrl.new_entry : prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
